FILE: hdl/fpca_pkg.sv
// Shared definitions for the fit-policy chunk allocator.
// Holds default sizes, header cost, field widths, fit-policy and status codes, and the scan control word.
// No dependencies.
package fpca_pkg;

    // default sizes of the byte buffer and the chunk table
    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int MAX_CHUNKS_DEF   = 128;

    // per-chunk header cost in bytes
    localparam int HEADER_BYTES = 9;

    // field widths fixed by the stream format
    localparam int AMOUNT_W     = 16;
    localparam int SUM_W        = 18;
    localparam int OUT_TDATA_W  = 80;
    localparam int OUT_PAD_W    = 5;

    // fit-policy codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_ALLOC    = 2'd2;
    localparam logic [1:0] ST_NO_FIT   = 2'd3;

    // control word from the sequencer to the candidate tracker
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [1:0] policy;
    } t_pick_ctl;

endpackage

FILE: hdl/fit_policy_chunk_allocator.sv
// Fit-policy chunk allocator: top level with sequencer, counters and output register.
// Instantiates fpca_table and fpca_pick; depends on fpca_pkg.
//
// An add word writes one table entry unless it is rejected, and its result is held
// in result registers until the output register is free; an allocate word reads
// every stored chunk once through the single read port of the table, and the picked
// entry's used count is written back in the last scan cycle before its result is
// held the same way; with no chunks stored it gives no fit without a scan. A new
// word is taken in the cycle after the previous result moves to the output register,
// even while that result still waits to be taken, but never before that move. The
// table has no reset pass: only entries below the chunk count are ever read. The
// policy register may be written at any time the block is idle.
module fit_policy_chunk_allocator #(
    parameter int BUFFER_BYTES = fpca_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_CHUNKS   = fpca_pkg::MAX_CHUNKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: fit_policy[1:0]
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_data,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [15:0]                      i_s_tdata,  // amount[15:0]
    input  logic [0:0]                       i_s_tuser,  // operation[0]
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // chunk_index[6:0], chunk_offset[16:7], used_after[26:17],
    // rejected_chunks[42:27], rejected_bytes[74:43], zero[79:75]
    output logic [fpca_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]                       o_m_tuser   // status[1:0]
);

    localparam int CAP_W = $clog2(BUFFER_BYTES);
    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int ENT_W = 3 * CAP_W;

    localparam logic [fpca_pkg::SUM_W-1:0] BUF_LIM = fpca_pkg::SUM_W'(BUFFER_BYTES);
    localparam logic [fpca_pkg::SUM_W-1:0] HDR     = fpca_pkg::SUM_W'(fpca_pkg::HEADER_BYTES);
    localparam logic [CNT_W-1:0]           CNT_MAX = CNT_W'(MAX_CHUNKS);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control state
    logic [1:0]       r_state,     n_state;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [CAP_W-1:0] r_fill,      n_fill;
    logic [IDX_W-1:0] r_nfp,       n_nfp;
    logic [15:0]      r_rej_cnt,   n_rej_cnt;
    logic [31:0]      r_rej_sum,   n_rej_sum;
    logic [1:0]       r_policy;
    logic             r_out_valid, n_out_valid;
    logic             r_rd_vld,    n_rd_vld;
    logic [CNT_W-1:0] r_left,      n_left;

    // payload
    logic [15:0]                      r_amount,   n_amount;
    logic [IDX_W-1:0]                 r_addr,     n_addr;
    logic [IDX_W-1:0]                 r_rd_idx,   n_rd_idx;
    logic [1:0]                       r_res_st,   n_res_st;
    logic [IDX_W-1:0]                 r_res_idx,  n_res_idx;
    logic [CAP_W-1:0]                 r_res_off,  n_res_off;
    logic [CAP_W-1:0]                 r_res_used, n_res_used;
    logic [fpca_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic [1:0]                       r_out_st,   n_out_st;

    // memory and tracker connections
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [ENT_W-1:0] mem_rdata;

    fpca_pkg::t_pick_ctl pick_ctl;
    logic                pick_found;
    logic [IDX_W-1:0]    pick_idx;
    logic [CAP_W-1:0]    pick_cap;
    logic [CAP_W-1:0]    pick_off;
    logic [CAP_W-1:0]    pick_used;

    logic                        s_acc;
    logic                        out_free;
    logic [fpca_pkg::SUM_W-1:0]  add_end;
    logic                        add_rej;
    logic [32:0]                 rej_sum_inc;
    logic [IDX_W-1:0]            scan_start;
    logic [CNT_W-1:0]            addr_inc;
    logic                        scan_end;
    logic [31:0]                 idx_w;
    logic [31:0]                 off_w;
    logic [31:0]                 used_w;

    assign o_cfg_ready = i_rst_n;
    assign o_s_tready  = i_rst_n && (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;

    // add-side arithmetic, next-fit start point and scan-end test
    always_comb begin
        add_end     = fpca_pkg::SUM_W'(r_fill) + HDR + fpca_pkg::SUM_W'(i_s_tdata);
        add_rej     = (r_count >= CNT_MAX) || (add_end >= BUF_LIM);
        rej_sum_inc = {1'b0, r_rej_sum} + 33'(i_s_tdata);
        scan_start  = (CNT_W'(r_nfp) < r_count) ? r_nfp : '0;
        addr_inc    = CNT_W'(r_addr) + CNT_W'(1);
        scan_end    = (r_left == '0) && !r_rd_vld;
        idx_w       = 32'(r_res_idx);
        off_w       = 32'(r_res_off);
        used_w      = 32'(r_res_used);
    end

    fpca_table #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_CHUNKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    fpca_pick #(
        .CAP_W (CAP_W),
        .IDX_W (IDX_W)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pick_ctl),
        .i_size     (r_amount),
        .i_idx      (r_rd_idx),
        .i_cap      (mem_rdata[3*CAP_W-1:2*CAP_W]),
        .i_used     (mem_rdata[2*CAP_W-1:CAP_W]),
        .i_off      (mem_rdata[CAP_W-1:0]),
        .o_found    (pick_found),
        .o_idx      (pick_idx),
        .o_cap      (pick_cap),
        .o_off      (pick_off),
        .o_used_new (pick_used)
    );

    // sequencer: add with a single table write, allocate by scanning the table;
    // write-back happens only after the last read returns, so no access overlaps
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_fill      = r_fill;
        n_nfp       = r_nfp;
        n_rej_cnt   = r_rej_cnt;
        n_rej_sum   = r_rej_sum;
        n_out_valid = r_out_valid;
        n_rd_vld    = r_rd_vld;
        n_left      = r_left;
        n_amount    = r_amount;
        n_addr      = r_addr;
        n_rd_idx    = r_rd_idx;
        n_res_st    = r_res_st;
        n_res_idx   = r_res_idx;
        n_res_off   = r_res_off;
        n_res_used  = r_res_used;
        n_out_data  = r_out_data;
        n_out_st    = r_out_st;
        mem_we      = 1'b0;
        mem_waddr   = r_count[IDX_W-1:0];
        mem_wdata   = {r_amount[CAP_W-1:0], {CAP_W{1'b0}}, r_fill};
        mem_re      = 1'b0;
        pick_ctl    = '{clear: 1'b0, step: r_rd_vld, policy: r_policy};

        // drop the output word once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_amount   = i_s_tdata;
                    n_res_idx  = '0;
                    n_res_off  = '0;
                    n_res_used = '0;
                    if (i_s_tuser[0] == 1'b0) begin
                        if (add_rej) begin
                            n_res_st = fpca_pkg::ST_REJECTED;
                            if (r_rej_cnt != 16'hFFFF) begin
                                n_rej_cnt = r_rej_cnt + 16'd1;
                            end
                            n_rej_sum = rej_sum_inc[32] ? 32'hFFFF_FFFF : rej_sum_inc[31:0];
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = {i_s_tdata[CAP_W-1:0], {CAP_W{1'b0}}, r_fill};
                            n_res_st  = fpca_pkg::ST_ADDED;
                            n_res_idx = r_count[IDX_W-1:0];
                            n_res_off = r_fill;
                            n_fill    = add_end[CAP_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_res_st = fpca_pkg::ST_NO_FIT;
                        n_state  = S_DONE;
                    end else begin
                        n_addr         = (r_policy == fpca_pkg::FIT_NEXT) ? scan_start : '0;
                        n_left         = r_count;
                        pick_ctl.clear = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    // issue the next read, wrapping at the chunk count
                    mem_re   = 1'b1;
                    n_left   = r_left - CNT_W'(1);
                    n_addr   = (addr_inc == r_count) ? '0 : addr_inc[IDX_W-1:0];
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (scan_end) begin
                    if (pick_found) begin
                        mem_we     = 1'b1;
                        mem_waddr  = pick_idx;
                        mem_wdata  = {pick_cap, pick_used, pick_off};
                        n_res_st   = fpca_pkg::ST_ALLOC;
                        n_res_idx  = pick_idx;
                        n_res_off  = pick_off;
                        n_res_used = pick_used;
                        if (r_policy == fpca_pkg::FIT_NEXT) begin
                            n_nfp = pick_idx;
                        end
                    end else begin
                        n_res_st = fpca_pkg::ST_NO_FIT;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // move the result into the output register when it is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_data  = {{fpca_pkg::OUT_PAD_W{1'b0}}, r_rej_sum, r_rej_cnt,
                                   used_w[9:0], off_w[9:0], idx_w[6:0]};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fill      <= '0;
            r_nfp       <= '0;
            r_rej_cnt   <= '0;
            r_rej_sum   <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_nfp       <= n_nfp;
            r_rej_cnt   <= n_rej_cnt;
            r_rej_sum   <= n_rej_sum;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
            r_left      <= n_left;
        end
    end

    // policy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fpca_pkg::FIT_FIRST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_amount   <= n_amount;
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_res_st   <= n_res_st;
        r_res_idx  <= n_res_idx;
        r_res_off  <= n_res_off;
        r_res_used <= n_res_used;
        r_out_data <= n_out_data;
        r_out_st   <= n_out_st;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_st;

`ifndef ASSERT_OFF
    // the chunk count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("chunk count exceeds table depth");

    // a table write never lands while a scan read is still returning
    a_no_write_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !r_rd_vld)
        else $error("table write overlaps a pending read");

    // a picked chunk stays within its capacity after the allocation
    a_pick_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_end && pick_found) |-> (pick_used <= pick_cap))
        else $error("picked chunk overflows its capacity");

    // a result is produced only after an item was accepted and worked on
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("output word loaded outside the done state");
`endif

endmodule

FILE: hdl/fpca_table.sv
// Chunk table memory: one write port, one read port, registered read data.
// Each entry packs capacity, used count and header offset.
// No package dependencies.
module fpca_table #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read one entry into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fpca_pick.sv
// Candidate tracker for the allocation scan: tests each entry for fit and
// keeps the chosen chunk by policy. Depends on fpca_pkg.
module fpca_pick #(
    parameter int CAP_W = 10,
    parameter int IDX_W = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpca_pkg::t_pick_ctl           i_ctl,
    input  logic [fpca_pkg::AMOUNT_W-1:0] i_size,
    input  logic [IDX_W-1:0]              i_idx,
    input  logic [CAP_W-1:0]              i_cap,
    input  logic [CAP_W-1:0]              i_used,
    input  logic [CAP_W-1:0]              i_off,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_idx,
    output logic [CAP_W-1:0]              o_cap,
    output logic [CAP_W-1:0]              o_off,
    output logic [CAP_W-1:0]              o_used_new
);

    logic                          r_found;
    logic [IDX_W-1:0]              r_idx;
    logic [CAP_W-1:0]              r_cap;
    logic [CAP_W-1:0]              r_off;
    logic [CAP_W-1:0]              r_used_new;
    logic [fpca_pkg::AMOUNT_W:0]   sum;
    logic                          fit;
    logic                          better;
    logic                          take;

    // fit test: used + size within capacity
    always_comb begin
        sum = {1'b0, fpca_pkg::AMOUNT_W'(i_used)} + {1'b0, i_size};
        fit = (sum <= {1'b0, fpca_pkg::AMOUNT_W'(i_cap)});
    end

    // replace the held pick only on a strict improvement; ties keep the earlier one
    always_comb begin
        better = ((i_ctl.policy == fpca_pkg::FIT_BEST)  && (i_cap < r_cap)) ||
                 ((i_ctl.policy == fpca_pkg::FIT_WORST) && (i_cap > r_cap));
        take   = i_ctl.step && fit && (!r_found || better);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // hold the chosen entry and its updated used count
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx      <= i_idx;
            r_cap      <= i_cap;
            r_off      <= i_off;
            r_used_new <= sum[CAP_W-1:0];
        end
    end

    assign o_found    = r_found;
    assign o_idx      = r_idx;
    assign o_cap      = r_cap;
    assign o_off      = r_off;
    assign o_used_new = r_used_new;

endmodule
